// ----- rtl/core/cst_pkg.sv -----
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types and constants for the counting semaphore table.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int NUM_SEMS   = 32;
  localparam int MAX_PROCS  = 15;
  localparam int RING_SLOTS = MAX_PROCS + 1;

  localparam int ID_W    = 5;
  localparam int INIT_W  = 15;
  localparam int PROC_W  = 6;
  localparam int CNT_W   = 16;
  localparam int SLOT_W  = $clog2(NUM_SEMS);
  localparam int FILL_W  = $clog2(NUM_SEMS + 1);
  localparam int POS_W   = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int SIZE_W  = $clog2(RING_SLOTS + 1);
  localparam int WADDR_W = SLOT_W + POS_W;

  localparam logic signed [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
  localparam logic signed [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_WAIT   = 2'd1,
    CMD_SIGNAL = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_BAD_ID  = 2'd2,
    ST_Q_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  // One semaphore table entry: count and ring bookkeeping
  typedef struct packed {
    logic signed [CNT_W-1:0] count;
    logic [POS_W-1:0]        head;
    logic [POS_W-1:0]        tail;
    logic [SIZE_W-1:0]       size;
  } entry_t;

  // Advance a ring position with wrap
  function automatic logic [POS_W-1:0] ring_next(input logic [POS_W-1:0] pos);
    ring_next = (pos == POS_W'(RING_SLOTS - 1)) ? '0 : pos + POS_W'(1);
  endfunction

endpackage

// ----- rtl/core/counting_semaphore_table_core.sv -----
// ----------------------------------------------------------------------------
// counting_semaphore_table_core
// Table of counting semaphores with a FIFO ring of waiting processes each.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one command word: allocate,
//   wait or signal, with sem_id, init_value and proc_id. Output channel
//   (out_valid/out_ready) returns one result word per command: status,
//   alloc_id, caller_blocks, wake_valid and wake_proc.
//   The semaphore entry is read at the accepting edge, the execute state
//   updates it and writes or reads the waiter memory, and the pending
//   result registers hold the outcome until the response state loads it
//   into the output register. A new command is taken in the response state
//   of the previous one while the output is free, so the block can take a
//   new command before the last one is through.
//   Slots are handed out lowest first and never freed, so a fill counter
//   stands for the per-slot valid bits; reset clears it and the control
//   state at once, with no clearing pass. Memory contents are loaded at
//   allocation.
//   When the receiver stalls, the result word holds in the output register
//   and one more command may complete up to its final cycle before the
//   input side stops taking words.
// ----------------------------------------------------------------------------
module counting_semaphore_table_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  command,
  input  logic [cst_pkg::ID_W-1:0]    sem_id,
  input  logic [cst_pkg::INIT_W-1:0]  init_value,
  input  logic [cst_pkg::PROC_W-1:0]  proc_id,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic [cst_pkg::ID_W-1:0]    alloc_id,
  output logic                        caller_blocks,
  output logic                        wake_valid,
  output logic [cst_pkg::PROC_W-1:0]  wake_proc
);
  import cst_pkg::*;

  state_t state, state_next;

  // Memories
  entry_t           entry_mem [NUM_SEMS];
  logic [PROC_W-1:0] waiter_mem [NUM_SEMS * RING_SLOTS];

  entry_t            entry_rd;
  logic [PROC_W-1:0] waiter_rd;

  // Captured command word
  logic [1:0]        cmd_q;
  logic [ID_W-1:0]   id_q;
  logic [INIT_W-1:0] init_q;
  logic [PROC_W-1:0] proc_q;

  logic [FILL_W-1:0] alloc_count;

  // Pending result between update and delivery
  status_t         res_status, res_status_next;
  logic [ID_W-1:0] res_alloc, res_alloc_next;
  logic            res_blocks, res_blocks_next;
  logic            res_wake, res_wake_next;

  logic              accept, out_free, id_ok;
  logic              entry_we, waiter_we, waiter_re, alloc_inc;
  logic [SLOT_W-1:0] entry_waddr;
  entry_t            entry_wdata;
  logic [WADDR_W-1:0] waiter_waddr, waiter_raddr;
  logic signed [CNT_W-1:0] cnt_dec, cnt_inc;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) || (state == S_RESP && out_free);
  assign accept   = in_valid && in_ready;
  assign id_ok    = (FILL_W'(id_q) < alloc_count);
  assign cnt_dec  = (entry_rd.count == CNT_MIN) ? CNT_MIN : entry_rd.count - CNT_W'(1);
  assign cnt_inc  = (entry_rd.count == CNT_MAX) ? CNT_MAX : entry_rd.count + CNT_W'(1);

  // Hold state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode the command against the fetched entry
  always_comb begin
    state_next      = state;
    entry_we        = 1'b0;
    entry_waddr     = id_q[SLOT_W-1:0];
    entry_wdata     = entry_rd;
    waiter_we       = 1'b0;
    waiter_waddr    = {id_q[SLOT_W-1:0], entry_rd.tail};
    waiter_re       = 1'b0;
    waiter_raddr    = {id_q[SLOT_W-1:0], entry_rd.head};
    alloc_inc       = 1'b0;
    res_status_next = res_status;
    res_alloc_next  = res_alloc;
    res_blocks_next = res_blocks;
    res_wake_next   = res_wake;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next      = S_RESP;
        res_status_next = ST_OK;
        res_alloc_next  = '0;
        res_blocks_next = 1'b0;
        res_wake_next   = 1'b0;
        priority if (cmd_q == CMD_ALLOC) begin
          if (alloc_count == FILL_W'(NUM_SEMS)) begin
            res_status_next = ST_NO_FREE;
          end else begin
            entry_we          = 1'b1;
            alloc_inc         = 1'b1;
            entry_waddr       = alloc_count[SLOT_W-1:0];
            entry_wdata.count = CNT_W'(init_q);
            entry_wdata.head  = '0;
            entry_wdata.tail  = '0;
            entry_wdata.size  = '0;
            res_alloc_next    = ID_W'(alloc_count);
          end
        end else if (!id_ok || (cmd_q != CMD_WAIT && cmd_q != CMD_SIGNAL)) begin
          res_status_next = ST_BAD_ID;
        end else if (cmd_q == CMD_WAIT) begin
          if (cnt_dec[CNT_W-1]) begin
            if (entry_rd.size >= SIZE_W'(RING_SLOTS)) begin
              res_status_next = ST_Q_FULL;
            end else begin
              entry_we          = 1'b1;
              waiter_we         = 1'b1;
              entry_wdata.count = cnt_dec;
              entry_wdata.tail  = ring_next(entry_rd.tail);
              entry_wdata.size  = entry_rd.size + SIZE_W'(1);
              res_blocks_next   = 1'b1;
            end
          end else begin
            entry_we          = 1'b1;
            entry_wdata.count = cnt_dec;
          end
        end else begin
          entry_we          = 1'b1;
          entry_wdata.count = cnt_inc;
          if (entry_rd.size != '0) begin
            waiter_re        = 1'b1;
            entry_wdata.head = ring_next(entry_rd.head);
            entry_wdata.size = entry_rd.size - SIZE_W'(1);
            res_wake_next    = 1'b1;
          end
        end
      end
      S_RESP: begin
        if (out_free) state_next = accept ? S_EXEC : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Capture the command word and fetch its entry
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q    <= command;
      id_q     <= sem_id;
      init_q   <= init_value;
      proc_q   <= proc_id;
      entry_rd <= entry_mem[sem_id[SLOT_W-1:0]];
    end
    if (entry_we) entry_mem[entry_waddr] <= entry_wdata;
  end

  // Waiter ring storage
  always_ff @(posedge clk) begin
    if (waiter_we) waiter_mem[waiter_waddr] <= proc_q;
    if (waiter_re) waiter_rd <= waiter_mem[waiter_raddr];
  end

  // Advance the allocation count and hold the pending result
  always_ff @(posedge clk) begin
    if (rst) begin
      alloc_count <= '0;
    end else if (alloc_inc) begin
      alloc_count <= alloc_count + FILL_W'(1);
    end
    res_status <= res_status_next;
    res_alloc  <= res_alloc_next;
    res_blocks <= res_blocks_next;
    res_wake   <= res_wake_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_RESP && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (state == S_RESP && out_free) begin
      status        <= res_status;
      alloc_id      <= res_alloc;
      caller_blocks <= res_blocks;
      wake_valid    <= res_wake;
      wake_proc     <= res_wake ? waiter_rd : '0;
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    alloc_count <= FILL_W'(NUM_SEMS))
    else $error("allocation count past table size");

  a_block_wake_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(caller_blocks && wake_valid))
    else $error("wait and wake reported together");

  a_err_no_side: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (!caller_blocks && !wake_valid))
    else $error("error result carries block or wake");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_EXEC)
    else $error("accepted word not executed next cycle");
`endif

endmodule

// ----- test/counting_semaphore_table_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// counting_semaphore_table_core_tb
// Drives allocate, wait and signal commands into the semaphore table, with
// random gaps on the input side and random stalls on the output side. A
// behavioral copy of the table predicts every result word, and each word
// that comes out is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module counting_semaphore_table_core_tb;
  import cst_pkg::*;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam int COUNT_CEIL  = 32767;
  localparam int COUNT_FLOOR = -32768;
  localparam int RANDOM_WORDS = 1050;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    status_t             status;
    logic [ID_W-1:0]     alloc_id;
    logic                blocks;
    logic                woke;
    logic [PROC_W-1:0]   woke_proc;
  } sem_reply_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          command = 2'd0;
  logic [ID_W-1:0]     sem_id = '0;
  logic [INIT_W-1:0]   init_value = '0;
  logic [PROC_W-1:0]   proc_id = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          status;
  logic [ID_W-1:0]     alloc_id;
  logic                caller_blocks;
  logic                wake_valid;
  logic [PROC_W-1:0]   wake_proc;

  // Shadow copy of the semaphore table
  bit                  sem_live   [NUM_SEMS] = '{default: 1'b0};
  int                  sem_level  [NUM_SEMS] = '{default: 0};
  int                  ring_rd    [NUM_SEMS] = '{default: 0};
  int                  ring_wr    [NUM_SEMS] = '{default: 0};
  int                  ring_fill  [NUM_SEMS] = '{default: 0};
  logic [PROC_W-1:0]   parked     [NUM_SEMS][RING_SLOTS];

  sem_reply_t          replies_due[$];
  int                  words_accepted = 0;
  int                  words_checked = 0;
  int                  mismatches = 0;
  int                  cycle_count = 0;
  logic                quiet = 1'b0;

  counting_semaphore_table_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .sem_id        (sem_id),
    .init_value    (init_value),
    .proc_id       (proc_id),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .alloc_id      (alloc_id),
    .caller_blocks (caller_blocks),
    .wake_valid    (wake_valid),
    .wake_proc     (wake_proc)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result side at random, except in the quiet stretch
  always @(posedge clk) begin
    out_ready <= quiet || ($urandom_range(0, 99) >= 21);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Apply one command to the shadow table and return the word it yields
  function automatic sem_reply_t apply_command(input logic [1:0] cmd,
                                               input logic [ID_W-1:0] id,
                                               input logic [INIT_W-1:0] init,
                                               input logic [PROC_W-1:0] proc);
    sem_reply_t r;
    int slot;
    int next_level;
    r = '0;
    r.status = ST_OK;
    if (cmd == CMD_ALLOC) begin
      slot = -1;
      for (int s = NUM_SEMS - 1; s >= 0; s--) begin
        if (!sem_live[s]) slot = s;
      end
      if (slot < 0) begin
        r.status = ST_NO_FREE;
      end else begin
        sem_live[slot] = 1'b1;
        sem_level[slot] = int'(init);
        r.alloc_id = ID_W'(slot);
      end
    end else if (cmd == CMD_UNKNOWN || int'(id) >= NUM_SEMS || !sem_live[id]) begin
      r.status = ST_BAD_ID;
    end else if (cmd == CMD_WAIT) begin
      next_level = (sem_level[id] > COUNT_FLOOR) ? sem_level[id] - 1 : COUNT_FLOOR;
      if (next_level < 0) begin
        if (ring_fill[id] >= RING_SLOTS) begin
          r.status = ST_Q_FULL;
        end else begin
          parked[id][ring_wr[id]] = proc;
          ring_wr[id] = (ring_wr[id] + 1) % RING_SLOTS;
          ring_fill[id]++;
          sem_level[id] = next_level;
          r.blocks = 1'b1;
        end
      end else begin
        sem_level[id] = next_level;
      end
    end else begin
      sem_level[id] = (sem_level[id] < COUNT_CEIL) ? sem_level[id] + 1 : COUNT_CEIL;
      if (ring_fill[id] > 0) begin
        r.woke = 1'b1;
        r.woke_proc = parked[id][ring_rd[id]];
        ring_rd[id] = (ring_rd[id] + 1) % RING_SLOTS;
        ring_fill[id]--;
      end
    end
    return r;
  endfunction

  // Mostly small counts so that waits block, with the extremes mixed in
  function automatic logic [INIT_W-1:0] pick_init();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return INIT_W'($urandom_range(0, 3));
    if (pick == 6) return INIT_W'(COUNT_CEIL);
    if (pick == 7) return INIT_W'($urandom_range(0, COUNT_CEIL));
    return INIT_W'($urandom_range(0, 20));
  endfunction

  // Present one command word and hold it until accepted
  task automatic send_word(input logic [1:0] cmd, input logic [ID_W-1:0] id,
                           input logic [INIT_W-1:0] init, input logic [PROC_W-1:0] proc);
    if (!quiet && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (!quiet && $urandom_range(0, 99) < 21);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    sem_id     <= id;
    init_value <= init;
    proc_id    <= proc;
    do @(posedge clk); while (!in_ready);
    replies_due.push_back(apply_command(cmd, id, init, proc));
    words_accepted++;
  endtask

  // Stop sending and hold off until every pending word is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_checked != words_accepted);
  endtask

  // Compare each result word with the oldest prediction
  always @(posedge clk) begin
    sem_reply_t want;
    if (!rst && out_valid && out_ready) begin
      words_checked <= words_checked + 1;
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got status %0d", $time, status);
        mismatches++;
      end else begin
        want = replies_due.pop_front();
        if (status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, status);
          mismatches++;
        end
        if (alloc_id !== want.alloc_id) begin
          $display("%0t: alloc_id expected %0d, got %0d", $time, want.alloc_id, alloc_id);
          mismatches++;
        end
        if (caller_blocks !== want.blocks) begin
          $display("%0t: caller_blocks expected %0d, got %0d", $time, want.blocks,
                   caller_blocks);
          mismatches++;
        end
        if (wake_valid !== want.woke) begin
          $display("%0t: wake_valid expected %0d, got %0d", $time, want.woke, wake_valid);
          mismatches++;
        end
        if (wake_proc !== want.woke_proc) begin
          $display("%0t: wake_proc expected %0d, got %0d", $time, want.woke_proc, wake_proc);
          mismatches++;
        end
      end
    end
  end

  // Commands on an empty table and the unknown command
  task automatic test_unallocated();
    send_word(CMD_WAIT, 5'd0, '0, 6'd1);
    send_word(CMD_SIGNAL, 5'd31, '0, 6'd2);
    send_word(CMD_UNKNOWN, 5'd0, INIT_W'(COUNT_CEIL), 6'd63);
  endtask

  // First slots, with count extremes
  task automatic test_alloc_basic();
    send_word(CMD_ALLOC, 5'd31, '0, 6'd0);
    send_word(CMD_ALLOC, 5'd0, INIT_W'(COUNT_CEIL), 6'd63);
    send_word(CMD_ALLOC, 5'd17, INIT_W'(1), 6'd5);
    send_word(CMD_ALLOC, 5'd3, INIT_W'(COUNT_CEIL - 1), 6'd9);
  endtask

  // Upper saturation, non-blocking wait, signal on an empty ring, unknown command
  task automatic test_count_limits();
    send_word(CMD_SIGNAL, 5'd1, '0, 6'd0);
    send_word(CMD_SIGNAL, 5'd3, '0, 6'd0);
    send_word(CMD_SIGNAL, 5'd3, '0, 6'd0);
    send_word(CMD_WAIT, 5'd2, '0, 6'd12);
    send_word(CMD_SIGNAL, 5'd2, '0, 6'd0);
    send_word(CMD_UNKNOWN, 5'd1, '0, 6'd0);
  endtask

  // Block two callers and wake them in order
  task automatic test_block_and_wake();
    send_word(CMD_WAIT, 5'd0, '0, 6'd63);
    send_word(CMD_WAIT, 5'd0, '0, 6'd0);
    send_word(CMD_SIGNAL, 5'd0, '0, 6'd0);
    send_word(CMD_SIGNAL, 5'd0, '0, 6'd0);
    send_word(CMD_SIGNAL, 5'd0, '0, 6'd0);
  endtask

  // Fill one ring past its depth, then drain it and signal once more
  task automatic test_queue_full();
    while (ring_fill[0] < RING_SLOTS) begin
      send_word(CMD_WAIT, 5'd0, '0, PROC_W'($urandom));
    end
    send_word(CMD_WAIT, 5'd0, '0, PROC_W'($urandom));
    while (ring_fill[0] > 0) begin
      send_word(CMD_SIGNAL, 5'd0, '0, PROC_W'($urandom));
    end
    send_word(CMD_SIGNAL, 5'd0, '0, PROC_W'($urandom));
  endtask

  // Take every remaining slot, then ask for one more
  task automatic test_table_full();
    int free_slots;
    free_slots = 0;
    foreach (sem_live[s]) if (!sem_live[s]) free_slots++;
    repeat (free_slots) begin
      send_word(CMD_ALLOC, ID_W'($urandom), pick_init(), PROC_W'($urandom));
    end
    send_word(CMD_ALLOC, ID_W'($urandom), pick_init(), PROC_W'($urandom));
  endtask

  // Bursts of waits and signals on one semaphore, with noise words between
  task automatic test_random_mix();
    int sent;
    int burst_len;
    int wait_pct;
    logic [ID_W-1:0] target;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      quiet <= (sent >= 400 && sent < 600);
      if ($urandom_range(0, 99) < 10) begin
        send_word(2'($urandom_range(0, 3)), ID_W'($urandom), INIT_W'($urandom),
                  PROC_W'($urandom));
        sent++;
      end else begin
        target    = ID_W'($urandom_range(0, NUM_SEMS - 1));
        burst_len = $urandom_range(1, 24);
        wait_pct  = $urandom_range(25, 75);
        repeat (burst_len) begin
          if ($urandom_range(0, 99) < wait_pct) begin
            send_word(CMD_WAIT, target, INIT_W'($urandom), PROC_W'($urandom));
          end else begin
            send_word(CMD_SIGNAL, target, INIT_W'($urandom), PROC_W'($urandom));
          end
          sent++;
        end
      end
    end
    quiet <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_unallocated();
    test_alloc_basic();
    test_count_limits();
    test_block_and_wake();
    wait_drained();
    test_queue_full();
    wait_drained();
    test_table_full();
    wait_drained();
    test_random_mix();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
